[design/shdfg_pkg.sv]
// Shared constants, register indexes and reset values for the frequency governor.
package shdfg_pkg;

  localparam int FREQ_BITS_DEF = 23;
  localparam int PCT_W         = 7;
  localparam int HOLD_W        = 10;
  localparam int CFG_IDX_W     = 3;
  localparam int DIV_BASE      = 100;

  localparam logic [CFG_IDX_W-1:0] REG_BOOST_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_SAMPLES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_PERCENT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_MAX        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_MIN        = 3'd4;

  localparam logic [PCT_W-1:0]  BOOST_THRESHOLD_RST = 7'd95;
  localparam logic [HOLD_W-1:0] HOLD_SAMPLES_RST    = 10'd8;
  localparam logic [PCT_W-1:0]  DECAY_PERCENT_RST   = 7'd15;
  localparam logic [31:0]       FREQ_MAX_RST        = 32'd8388607;

endpackage

[design/shdfg_if.sv]
// Valid/ready channel interfaces for load samples and frequency targets.
interface shdfg_sample_if
  import shdfg_pkg::*;
#(
  parameter int FREQ_BITS = FREQ_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [PCT_W-1:0]     load_pct;
  logic [FREQ_BITS-1:0] current_freq;

  modport source (output valid, output load_pct, output current_freq, input ready);
  modport sink   (input valid, input load_pct, input current_freq, output ready);
endinterface

interface shdfg_target_if
  import shdfg_pkg::*;
#(
  parameter int FREQ_BITS = FREQ_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 target_valid;
  logic [FREQ_BITS-1:0] target_freq;
  logic                 pick_below;
  logic [HOLD_W-1:0]    hold_left;

  modport source (output valid, output target_valid, output target_freq,
                  output pick_below, output hold_left, input ready);
  modport sink   (input valid, input target_valid, input target_freq,
                  input pick_below, input hold_left, output ready);
endinterface

[design/spike_hold_decay_freq_governor_unit.sv]
// Spike-hold-decay frequency governor: boost on load spikes, hold, then linear decay.
// A result beat is registered in the cycle after its sample beat is accepted.
// One sample per cycle unless busy or stalled; the output register frees the input side.
// The decay step (decay_percent * freq_max / 100) comes from a three-stage pipeline;
// samples stall until it refills after reset and after writes to decay_percent or freq_max.
// Reset (synchronous, active high) restores register defaults, clears request and hold.
module spike_hold_decay_freq_governor_unit
  import shdfg_pkg::*;
#(
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FREQ_BITS-1:0] cfg_data,
  shdfg_sample_if.sink         sample,
  shdfg_target_if.source       result
);

  localparam int DIV_L    = $clog2(DIV_BASE);
  localparam int Q_W      = FREQ_BITS - DIV_L + 1;
  localparam int RCP_F_SH = FREQ_BITS + DIV_L;
  localparam int DR_W     = 2 * PCT_W;
  localparam int RCP_R_SH = DR_W + DIV_L;
  localparam int STEP_LAT = 3;
  localparam logic [FREQ_BITS:0] RCP_F =
    (FREQ_BITS+1)'(((64'd1 << RCP_F_SH) + 64'(DIV_BASE - 1)) / 64'(DIV_BASE));
  localparam logic [DR_W:0] RCP_R =
    (DR_W+1)'(((64'd1 << RCP_R_SH) + 64'(DIV_BASE - 1)) / 64'(DIV_BASE));

  logic [PCT_W-1:0]     boost_threshold;
  logic [HOLD_W-1:0]    hold_samples;
  logic [PCT_W-1:0]     decay_percent;
  logic [FREQ_BITS-1:0] freq_max;
  logic [FREQ_BITS-1:0] freq_min;

  logic [FREQ_BITS-1:0] requested;
  logic [HOLD_W-1:0]    hold_count;

  // step pipeline
  logic [2*FREQ_BITS:0] q_prod;
  logic [FREQ_BITS-1:0] q_x100;
  logic [PCT_W-1:0]     rem_f;
  logic [2*DR_W:0]      dr_prod;
  logic [Q_W-1:0]       step_q;
  logic [FREQ_BITS:0]   step_dq;
  logic [DR_W-1:0]      step_dr;
  logic [FREQ_BITS:0]   decay_step;
  logic [1:0]           step_wait;
  logic                 busy;

  logic                 out_valid;
  logic                 accept;

  logic [FREQ_BITS-1:0] req_eff;
  logic                 boost;
  logic [FREQ_BITS-1:0] decayed;
  logic [FREQ_BITS-1:0] diff;
  logic [FREQ_BITS-1:0] requested_next;
  logic [HOLD_W-1:0]    hold_count_next;
  logic                 tv_next;
  logic                 below_next;
  logic [FREQ_BITS-1:0] target_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      boost_threshold <= BOOST_THRESHOLD_RST;
      hold_samples    <= HOLD_SAMPLES_RST;
      decay_percent   <= DECAY_PERCENT_RST;
      freq_max        <= FREQ_BITS'(FREQ_MAX_RST);
      freq_min        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOOST_THRESHOLD: boost_threshold <= cfg_data[PCT_W-1:0];
        REG_HOLD_SAMPLES:    hold_samples    <= cfg_data[HOLD_W-1:0];
        REG_DECAY_PERCENT:   decay_percent   <= cfg_data[PCT_W-1:0];
        REG_FREQ_MAX:        freq_max        <= cfg_data;
        REG_FREQ_MIN:        freq_min        <= cfg_data;
        default: ;
      endcase
    end
  end

  // split freq_max = 100*q + r, then step = d*q + (d*r)/100, by reciprocal multiplication
  assign q_prod  = (2*FREQ_BITS+1)'(freq_max) * (2*FREQ_BITS+1)'(RCP_F);
  assign q_x100  = FREQ_BITS'(step_q) * FREQ_BITS'(DIV_BASE);
  assign rem_f   = PCT_W'(freq_max - q_x100);
  assign dr_prod = (2*DR_W+1)'(step_dr) * (2*DR_W+1)'(RCP_R);

  always_ff @(posedge clk) begin
    step_q     <= q_prod[RCP_F_SH +: Q_W];
    step_dq    <= (FREQ_BITS+1)'(decay_percent) * (FREQ_BITS+1)'(step_q);
    step_dr    <= DR_W'(decay_percent) * DR_W'(rem_f);
    decay_step <= step_dq + (FREQ_BITS+1)'(dr_prod[RCP_R_SH +: PCT_W+1]);
  end

  // hold samples until the pipeline has refilled
  always_ff @(posedge clk) begin
    if (rst) begin
      step_wait <= 2'(STEP_LAT);
    end else if (cfg_we && (cfg_index == REG_DECAY_PERCENT || cfg_index == REG_FREQ_MAX)) begin
      step_wait <= 2'(STEP_LAT);
    end else if (step_wait != '0) begin
      step_wait <= step_wait - 1'b1;
    end
  end

  assign busy = (step_wait != '0);

  // per-sample decision
  always_comb begin
    req_eff = ((requested > freq_max) || (requested < freq_min)) ? sample.current_freq
                                                                  : requested;
    boost   = (sample.load_pct >= boost_threshold);
    diff    = req_eff - decay_step[FREQ_BITS-1:0];
    if ((decay_step >= {1'b0, req_eff}) || (diff < freq_min)) begin
      decayed = freq_min;
    end else begin
      decayed = diff;
    end

    requested_next  = requested;
    hold_count_next = hold_count;
    tv_next         = 1'b0;
    below_next      = 1'b0;
    target_next     = '0;
    priority if (boost) begin
      hold_count_next = hold_samples;
      requested_next  = freq_max;
      tv_next         = 1'b1;
      below_next      = 1'b1;
      target_next     = freq_max;
    end else if (hold_count != '0) begin
      hold_count_next = hold_count - 1'b1;
    end else if (req_eff > freq_min) begin
      requested_next = decayed;
      tv_next        = 1'b1;
      target_next    = decayed;
    end
  end

  assign sample.ready = !busy && (!out_valid || result.ready);
  assign accept       = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      requested  <= '0;
      hold_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        requested  <= requested_next;
        hold_count <= hold_count_next;
        out_valid  <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold result payload until its beat is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      result.target_valid <= tv_next;
      result.target_freq  <= target_next;
      result.pick_below   <= below_next;
      result.hold_left    <= hold_count_next;
    end
  end

  assign result.valid = out_valid;

`ifndef ASSERT_OFF
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !sample.ready)
    else $error("sample accepted while decay step is being computed");

  a_idle_target_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.target_valid) |-> (result.target_freq == '0 && !result.pick_below))
    else $error("target fields nonzero without a target");

  a_boost_reloads_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && boost) |=> (result.hold_left == $past(hold_samples) && result.pick_below))
    else $error("boost did not reload hold counter");

  a_hold_counts_down: assert property (@(posedge clk) disable iff (rst)
    (accept && !boost && hold_count != '0) |=> (hold_count == $past(hold_count) - 1'b1 &&
                                                !result.target_valid))
    else $error("hold counter did not step down");
`endif

endmodule
